>>> rtl/core/sidi_pkg.sv
// shared constants and types for the sorted identity set
// no dependencies
`default_nettype none
package sidi_pkg;

  // set capacity and field widths
  localparam int SET_DEPTH = 256;
  localparam int ID_W      = 34;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int IDX_W     = $clog2(SET_DEPTH);
  localparam int SLOT_W    = 9;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((ID_W + 7) / 8) * 8;
  localparam int OUT_FLD_W   = 3 + SLOT_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic             capture;
    logic             write;
    logic [CNT_W-1:0] slot;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/sidi_cell.sv
// one storage cell of the sorted chain: holds one entry, compares it with the
// broadcast identity and takes its left neighbour's entry on insert; uses sidi_pkg
`default_nettype none
module sidi_cell (
  input  wire logic                       clk,
  input  wire logic [sidi_pkg::IDX_W-1:0] cell_idx,
  input  wire logic [sidi_pkg::CNT_W-1:0] entry_count,
  input  wire sidi_pkg::cell_cmd_t        cmd,
  input  wire logic [sidi_pkg::ID_W-1:0]  id_value,
  input  wire logic [sidi_pkg::ID_W-1:0]  prev_data,
  output logic      [sidi_pkg::ID_W-1:0]  data_o,
  output logic                            less_o,
  output logic                            eq_o
);

  logic [sidi_pkg::ID_W-1:0]  data_r;
  logic                       less_r;
  logic                       eq_r;
  logic [sidi_pkg::CNT_W-1:0] idx_ext;
  logic                       valid;

  assign idx_ext = sidi_pkg::CNT_W'(cell_idx);
  // entry is live when it sits below the fill count
  assign valid   = idx_ext < entry_count;

  // compare flags, taken once per transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      less_r <= valid && (data_r < id_value);
      eq_r   <= valid && (data_r == id_value);
    end
  end

  // insert: cells above the slot shift up, the slot cell takes the new value
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      if (idx_ext > cmd.slot) begin
        data_r <= prev_data;
      end else if (idx_ext == cmd.slot) begin
        data_r <= id_value;
      end
    end
  end

  assign data_o = data_r;
  assign less_o = less_r;
  assign eq_o   = eq_r;

endmodule
`default_nettype wire

>>> rtl/core/sidi_ctrl.sv
// sequencer: latches the identity, runs the binary search over the cells'
// compare flags, drives the insert and holds the result register; uses sidi_pkg
`default_nettype none
module sidi_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sidi_pkg::ID_W-1:0]        in_id,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic                                  out_found,
  output logic                                  out_inserted,
  output logic                                  out_set_full,
  output logic      [sidi_pkg::SLOT_W-1:0]      out_slot,
  input  wire logic [sidi_pkg::SET_DEPTH-1:0]   less_vec,
  input  wire logic [sidi_pkg::SET_DEPTH-1:0]   eq_vec,
  output logic      [sidi_pkg::ID_W-1:0]        id_o,
  output logic      [sidi_pkg::CNT_W-1:0]       count_o,
  output sidi_pkg::cell_cmd_t                   cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [sidi_pkg::CNT_W-1:0] FULL_CNT = sidi_pkg::CNT_W'(sidi_pkg::SET_DEPTH);
  localparam logic [sidi_pkg::CNT_W-1:0] ONE_CNT  = sidi_pkg::CNT_W'(1);

  logic [1:0]                  state_r, state_nxt;
  logic [sidi_pkg::ID_W-1:0]   id_r;
  logic [sidi_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [sidi_pkg::CNT_W-1:0]  lo_r, lo_nxt;
  logic [sidi_pkg::CNT_W-1:0]  hi_r, hi_nxt;
  logic                        found_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_ins_r, out_full_r;
  logic [sidi_pkg::SLOT_W-1:0] out_slot_r;
  logic [sidi_pkg::CNT_W-1:0]  mid;
  logic                        fin_go;
  logic                        is_full;
  logic                        do_ins;

  assign in_tready = (state_r == ST_IDLE);
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign is_full   = !found_r && (count_r == FULL_CNT);
  assign do_ins    = fin_go && !found_r && !is_full;

  // sequencing and search bounds
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        lo_nxt    = '0;
        hi_nxt    = count_r;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          if (less_vec[mid[sidi_pkg::IDX_W-1:0]]) begin
            lo_nxt = mid + ONE_CNT;
          end else begin
            hi_nxt = mid;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
          if (do_ins) begin
            count_nxt = count_r + ONE_CNT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid: drops on a taken transaction, set when a result is loaded
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (in_tvalid && in_tready) begin
      id_r <= in_id;
    end
    if (state_r == ST_SRCH) begin
      found_r <= |eq_vec;
    end
    if (fin_go) begin
      out_found_r <= found_r;
      out_ins_r   <= !found_r && !is_full;
      out_full_r  <= is_full;
      out_slot_r  <= sidi_pkg::SLOT_W'(lo_r);
    end
  end

  // broadcast to the cells
  assign cmd_o.capture = (state_r == ST_CMP);
  assign cmd_o.write   = do_ins;
  assign cmd_o.slot    = lo_r;
  assign id_o          = id_r;
  assign count_o       = count_r;

  assign out_tvalid   = out_valid_r;
  assign out_found    = out_found_r;
  assign out_inserted = out_ins_r;
  assign out_set_full = out_full_r;
  assign out_slot     = out_slot_r;

endmodule
`default_nettype wire

>>> rtl/core/sorted_id_set_insert.sv
// Sorted identity set with lookup-and-insert: a row of sidi_cell entries and
// the sidi_ctrl sequencer. The search makes at most ceil(log2(count+1)) probes,
// one per cycle, over the cells' compare flags. One item in work at a time: the
// next input is taken only once the current one has loaded its result, which
// waits while the previous result is still held. Sync active-low reset empties
// the set.
`default_nettype none
module sorted_id_set_insert (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [33:0] id_value
  input  wire logic [sidi_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [0] found, [1] inserted, [2] set_full, [11:3] slot_index
  output logic      [sidi_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic [sidi_pkg::SET_DEPTH-1:0] less_vec;
  logic [sidi_pkg::SET_DEPTH-1:0] eq_vec;
  logic [sidi_pkg::ID_W-1:0]      cell_data [sidi_pkg::SET_DEPTH];
  logic [sidi_pkg::ID_W-1:0]      id_bcast;
  logic [sidi_pkg::CNT_W-1:0]     count;
  sidi_pkg::cell_cmd_t            cmd;
  logic                           o_found, o_ins, o_full;
  logic [sidi_pkg::SLOT_W-1:0]    o_slot;

  // sequencer and result register
  sidi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_id        (in_tdata[sidi_pkg::ID_W-1:0]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_found    (o_found),
    .out_inserted (o_ins),
    .out_set_full (o_full),
    .out_slot     (o_slot),
    .less_vec     (less_vec),
    .eq_vec       (eq_vec),
    .id_o         (id_bcast),
    .count_o      (count),
    .cmd_o        (cmd)
  );

  // chain of entry cells, each fed by its left neighbour, the first by the broadcast id
  for (genvar i = 0; i < sidi_pkg::SET_DEPTH; i++) begin : g_cell
    logic [sidi_pkg::ID_W-1:0] prev;
    if (i == 0) begin : g_first
      assign prev = id_bcast;
    end else begin : g_rest
      assign prev = cell_data[i-1];
    end
    sidi_cell u_cell (
      .clk         (clk),
      .cell_idx    (sidi_pkg::IDX_W'(i)),
      .entry_count (count),
      .cmd         (cmd),
      .id_value    (id_bcast),
      .prev_data   (prev),
      .data_o      (cell_data[i]),
      .less_o      (less_vec[i]),
      .eq_o        (eq_vec[i])
    );
  end

  // pack the result fields, zero padded
  assign out_tdata = sidi_pkg::OUT_TDATA_W'({o_slot, o_full, o_ins, o_found});

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// checks sorted_id_set_insert against its own mirror of the sorted identity set
// depends on sidi_pkg and the sorted_id_set_insert rtl; no other files
`timescale 1ns / 100ps
module testbench;
  import sidi_pkg::*;

  localparam logic [ID_W-1:0] ID_MAX     = '1;
  localparam logic [ID_W-1:0] TEN_DIGITS = 34'd9999999999;

  typedef struct {
    logic              found;
    logic              inserted;
    logic              set_full;
    logic [SLOT_W-1:0] slot;
  } lookup_result_t;

  // mirror of the set contents and the queue of lookup results still owed
  class sorted_id_mirror;
    logic [ID_W-1:0] ids [SET_DEPTH];
    int              entry_count = 0;
    int              mismatch_count = 0;
    lookup_result_t  pending_lookups [$];

    // accepted id: search, insert if absent and room, queue the outcome
    function void take_id(logic [ID_W-1:0] v);
      int lo;
      int hi;
      int mid;
      lookup_result_t r;
      lo = 0;
      hi = entry_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (ids[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      r.found    = 1'b0;
      r.inserted = 1'b0;
      r.set_full = 1'b0;
      r.slot     = SLOT_W'(lo);
      if (lo < entry_count && ids[lo] == v) begin
        r.found = 1'b1;
      end else if (entry_count >= SET_DEPTH) begin
        r.set_full = 1'b1;
      end else begin
        for (int i = entry_count; i > lo; i--) ids[i] = ids[i-1];
        ids[lo] = v;
        entry_count++;
        r.inserted = 1'b1;
      end
      pending_lookups.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    // accepted result transaction against the oldest outcome owed
    function void match_result(logic [OUT_TDATA_W-1:0] d);
      lookup_result_t r;
      if (pending_lookups.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, d);
        mismatch_count++;
        return;
      end
      r = pending_lookups.pop_front();
      compare_field("found", r.found, d[0]);
      compare_field("inserted", r.inserted, d[1]);
      compare_field("set_full", r.set_full, d[2]);
      compare_field("slot_index", r.slot, d[3 +: SLOT_W]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic                   quiet = 1'b0;
  logic [ID_W-1:0]        sent_ids [$];
  sorted_id_mirror        mirror = new();

  sorted_id_set_insert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fresh id: whole range, ten-digit range, neighbours of earlier ids, both ends
  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] v;
    logic [ID_W-1:0] d;
    v[31:0]  = $urandom;
    v[33:32] = 2'($urandom_range(3, 0));
    d        = ID_W'($urandom_range(1, 4));
    case ($urandom_range(0, 4))
      1: v = ID_W'(64'(v) % (64'(TEN_DIGITS) + 64'd1));
      2: if (sent_ids.size() > 0) begin
        v = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
        v = $urandom_range(0, 1) ? v + d : v - d;
      end
      3: v = ID_W'($urandom_range(2, 500));
      4: v = ID_MAX - ID_W'($urandom_range(1, 500));
      default: ;
    endcase
    // zero and all-ones are kept back for the full-set checks
    if (v == '0 || v == ID_MAX) v = ID_W'(2);
    return v;
  endfunction

  // mostly new ids, some repeats of earlier ones
  function automatic logic [ID_W-1:0] next_id();
    if (sent_ids.size() > 0 && $urandom_range(0, 99) < 30)
      return sent_ids[$urandom_range(0, sent_ids.size() - 1)];
    return fresh_id();
  endfunction

  // one input transaction, at times with a random idle burst ahead of it
  task automatic offer_id(logic [ID_W-1:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.take_id(v);
    sent_ids.push_back(v);
  endtask

  // result side: check accepted transactions, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) mirror.match_result(out_tdata);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [ID_W-1:0] opening_ids [17];
    logic [ID_W-1:0] full_set_ids [6];
    opening_ids = '{34'd1, TEN_DIGITS, ID_MAX - 1, 34'd1, TEN_DIGITS + 1, 34'd5000000000,
                    34'h2AAAAAAAA, 34'h155555555, 34'd2, TEN_DIGITS - 1, TEN_DIGITS,
                    ID_MAX - 1, 34'h000000FFF, 34'h3FFFFF000, 34'd5000000001,
                    34'd4999999999, 34'd2};
    // below every entry, above every entry, and present while full
    full_set_ids = '{34'd0, ID_MAX, ID_MAX, 34'd1, ID_MAX - 1, 34'd0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both ends of the range, bit patterns, repeats
    foreach (opening_ids[i]) offer_id(opening_ids[i]);

    // random until the set is full
    while (mirror.entry_count < SET_DEPTH) offer_id(next_id());

    foreach (full_set_ids[i]) offer_id(full_set_ids[i]);

    // random against the full set, with the tail run free of idling
    for (int i = 0; i < 230; i++) begin
      if (i == 170) quiet = 1'b1;
      offer_id(next_id());
    end
    in_tvalid <= 1'b0;

    while (mirror.pending_lookups.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mirror.pending_lookups.size() != 0)
      $display("%0t missing results: expected 0 outstanding, actual %0d", $time,
               mirror.pending_lookups.size());
    if (mirror.mismatch_count == 0 && mirror.pending_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, many times the slowest legal run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sidi_pkg.sv
rtl/core/sidi_cell.sv
rtl/core/sidi_ctrl.sv
rtl/core/sorted_id_set_insert.sv
tb/sv/testbench.sv
